/* src/accumulator_cpu_execute_unit_top_macros.svh */
// assertion macros for the accumulator cpu execute unit
// used by accumulator_cpu_execute_unit_top; expects clock and reset in scope
`ifndef ACCUMULATOR_CPU_EXECUTE_UNIT_TOP_MACROS_SVH
`define ACCUMULATOR_CPU_EXECUTE_UNIT_TOP_MACROS_SVH

// same-cycle implication
`define ACPU_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("acpu assertion failed");

// next-cycle implication
`define ACPU_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("acpu assertion failed");

`endif

/* src/acpu_pkg.sv */
// shared types and constants for the accumulator cpu execute unit
// no dependencies
`timescale 1ns / 1ps

package acpu_pkg;

   localparam int WORD_W = 16;
   localparam int MODE_W = 6;
   localparam int FLAG_W = 4;

   localparam int FLAG_N_BIT = 3;
   localparam int FLAG_Z_BIT = 2;
   localparam int FLAG_V_BIT = 1;
   localparam int FLAG_C_BIT = 0;

   localparam logic [WORD_W-1:0] SIGN_MIN  = 16'h8000;
   localparam logic [WORD_W-1:0] LOW_MASK  = 16'h00ff;
   localparam logic [WORD_W-1:0] HIGH_MASK = 16'hff00;
   localparam logic [7:0]        BYTE_SIGN = 8'h80;

   localparam logic [MODE_W-1:0] MODE_BR      = 6'd0;
   localparam logic [MODE_W-1:0] MODE_BRLE    = 6'd1;
   localparam logic [MODE_W-1:0] MODE_BRLT    = 6'd2;
   localparam logic [MODE_W-1:0] MODE_BREQ    = 6'd3;
   localparam logic [MODE_W-1:0] MODE_BRNE    = 6'd4;
   localparam logic [MODE_W-1:0] MODE_BRGE    = 6'd5;
   localparam logic [MODE_W-1:0] MODE_BRGT    = 6'd6;
   localparam logic [MODE_W-1:0] MODE_BRV     = 6'd7;
   localparam logic [MODE_W-1:0] MODE_BRC     = 6'd8;
   localparam logic [MODE_W-1:0] MODE_CALL    = 6'd9;
   localparam logic [MODE_W-1:0] MODE_ADDSP   = 6'd10;
   localparam logic [MODE_W-1:0] MODE_SUBSP   = 6'd11;
   localparam logic [MODE_W-1:0] MODE_ADD     = 6'd12;
   localparam logic [MODE_W-1:0] MODE_SUB     = 6'd14;
   localparam logic [MODE_W-1:0] MODE_AND     = 6'd16;
   localparam logic [MODE_W-1:0] MODE_OR      = 6'd18;
   localparam logic [MODE_W-1:0] MODE_CPW     = 6'd20;
   localparam logic [MODE_W-1:0] MODE_CPB     = 6'd22;
   localparam logic [MODE_W-1:0] MODE_LDW     = 6'd24;
   localparam logic [MODE_W-1:0] MODE_LDB     = 6'd26;
   localparam logic [MODE_W-1:0] MODE_STW     = 6'd28;
   localparam logic [MODE_W-1:0] MODE_STB     = 6'd30;
   localparam logic [MODE_W-1:0] MODE_NOT     = 6'd32;
   localparam logic [MODE_W-1:0] MODE_NEG     = 6'd34;
   localparam logic [MODE_W-1:0] MODE_ASL     = 6'd36;
   localparam logic [MODE_W-1:0] MODE_ASR     = 6'd38;
   localparam logic [MODE_W-1:0] MODE_ROL     = 6'd40;
   localparam logic [MODE_W-1:0] MODE_ROR_X   = 6'd43;
   localparam logic [MODE_W-1:0] MODE_MOVFLGA = 6'd44;
   localparam logic [MODE_W-1:0] MODE_MOVAFLG = 6'd45;
   localparam logic [MODE_W-1:0] MODE_STOP    = 6'd46;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [WORD_W-1:0] operand;
      logic [WORD_W-1:0] next_pc;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] acc;
      logic [WORD_W-1:0] idx;
      logic [WORD_W-1:0] sp;
      logic [FLAG_W-1:0] flags;
   } arch_type;

   typedef struct packed {
      logic [WORD_W-1:0] new_pc;
      logic              store_valid;
      logic              store_byte;
      logic [WORD_W-1:0] store_address;
      logic [WORD_W-1:0] store_data;
      logic              halt;
      logic              illegal;
   } rsp_type;

endpackage

/* src/acpu_exec.sv */
// execute logic: one operation against the architectural state
// depends on acpu_pkg
`timescale 1ns / 1ps

module acpu_exec import acpu_pkg::*; (
   input  req_type  req,
   input  arch_type cur,
   output arch_type nxt,
   output rsp_type  rsp
);

   logic [MODE_W-1:0] op_base;
   logic [WORD_W-1:0] rv;
   logic [WORD_W-1:0] op;
   logic [WORD_W-1:0] t;
   logic [WORD_W:0]   wide;
   logic [WORD_W-1:0] diff;
   logic              wr_reg;
   logic              take;
   logic [FLAG_W-1:0] f;
   logic [1:0]        keep_vc;

   assign op_base = {req.mode[MODE_W-1:1], 1'b0};
   assign rv      = req.mode[0] ? cur.idx : cur.acc;
   assign op      = req.operand;
   assign keep_vc = cur.flags[FLAG_V_BIT:FLAG_C_BIT];
   assign diff    = rv - op;

   always_comb begin
      nxt    = cur;
      rsp    = '0;
      rsp.new_pc = req.next_pc;
      t      = '0;
      wide   = '0;
      wr_reg = 1'b0;
      take   = 1'b0;
      f      = cur.flags;
      unique case (req.mode) inside
         [MODE_BR:MODE_BRC]: begin
            unique case (req.mode)
               MODE_BR:   take = 1'b1;
               MODE_BRLE: take = cur.flags[FLAG_N_BIT] | cur.flags[FLAG_Z_BIT];
               MODE_BRLT: take = cur.flags[FLAG_N_BIT];
               MODE_BREQ: take = cur.flags[FLAG_Z_BIT];
               MODE_BRNE: take = ~cur.flags[FLAG_Z_BIT];
               MODE_BRGE: take = ~cur.flags[FLAG_N_BIT];
               MODE_BRGT: take = ~cur.flags[FLAG_N_BIT] & ~cur.flags[FLAG_Z_BIT];
               MODE_BRV:  take = cur.flags[FLAG_V_BIT];
               default:   take = cur.flags[FLAG_C_BIT];
            endcase
            if (take) begin
               rsp.new_pc = op;
            end
         end
         MODE_CALL: begin
            nxt.sp            = cur.sp - 16'd2;
            rsp.store_valid   = 1'b1;
            rsp.store_address = cur.sp - 16'd2;
            rsp.store_data    = req.next_pc;
            rsp.new_pc        = op;
         end
         MODE_ADDSP: nxt.sp = cur.sp + op;
         MODE_SUBSP: nxt.sp = cur.sp - op;
         [MODE_ADD:MODE_ROR_X]: begin
            unique case (op_base) inside
               MODE_ADD: begin
                  wide   = {1'b0, rv} + {1'b0, op};
                  t      = wide[WORD_W-1:0];
                  wr_reg = 1'b1;
                  f = {t[WORD_W-1], t == '0,
                       ~(rv[WORD_W-1] ^ op[WORD_W-1]) & (rv[WORD_W-1] ^ t[WORD_W-1]),
                       wide[WORD_W]};
               end
               MODE_SUB, MODE_CPW: begin
                  wide   = {1'b0, rv} + {1'b0, ~op} + 17'd1;
                  t      = wide[WORD_W-1:0];
                  wr_reg = (op_base == MODE_SUB);
                  f = {t[WORD_W-1], t == '0,
                       (rv[WORD_W-1] ^ op[WORD_W-1]) & (rv[WORD_W-1] ^ t[WORD_W-1]),
                       wide[WORD_W]};
                  if (op_base == MODE_CPW && f[FLAG_V_BIT]) begin
                     f[FLAG_N_BIT] = ~f[FLAG_N_BIT];
                  end
               end
               MODE_AND: begin
                  t      = rv & op;
                  wr_reg = 1'b1;
                  f      = {t[WORD_W-1], t == '0, keep_vc};
               end
               MODE_OR: begin
                  t      = rv | op;
                  wr_reg = 1'b1;
                  f      = {t[WORD_W-1], t == '0, keep_vc};
               end
               MODE_CPB: begin
                  f = {(diff[7:0] & BYTE_SIGN) != 8'd0, diff[7:0] == 8'd0, 2'b00};
               end
               MODE_LDW: begin
                  t      = op;
                  wr_reg = 1'b1;
                  f      = {t[WORD_W-1], t == '0, keep_vc};
               end
               MODE_LDB: begin
                  t      = (rv & HIGH_MASK) | (op & LOW_MASK);
                  wr_reg = 1'b1;
                  f      = {1'b0, t[7:0] == 8'd0, keep_vc};
               end
               MODE_STW: begin
                  rsp.store_valid   = 1'b1;
                  rsp.store_address = op;
                  rsp.store_data    = rv;
               end
               MODE_STB: begin
                  rsp.store_valid   = 1'b1;
                  rsp.store_byte    = 1'b1;
                  rsp.store_address = op;
                  rsp.store_data    = rv & LOW_MASK;
               end
               MODE_NOT: begin
                  t      = ~rv;
                  wr_reg = 1'b1;
                  f      = {t[WORD_W-1], t == '0, keep_vc};
               end
               MODE_NEG: begin
                  t      = 16'd0 - rv;
                  wr_reg = 1'b1;
                  f      = {t[WORD_W-1], t == '0, t == SIGN_MIN, rv == '0};
               end
               MODE_ASL: begin
                  t      = {rv[WORD_W-2:0], 1'b0};
                  wr_reg = 1'b1;
                  f = {t[WORD_W-1], t == '0, rv[WORD_W-1] ^ t[WORD_W-1], rv[WORD_W-1]};
               end
               MODE_ASR: begin
                  t      = {rv[WORD_W-1], rv[WORD_W-1:1]};
                  wr_reg = 1'b1;
                  f      = {t[WORD_W-1], t == '0, 1'b0, rv[0]};
               end
               MODE_ROL: begin
                  t      = {rv[WORD_W-2:0], cur.flags[FLAG_C_BIT]};
                  wr_reg = 1'b1;
                  f[FLAG_C_BIT] = rv[WORD_W-1];
               end
               default: begin
                  t      = {cur.flags[FLAG_C_BIT], rv[WORD_W-1:1]};
                  wr_reg = 1'b1;
                  f[FLAG_C_BIT] = rv[0];
               end
            endcase
            if (wr_reg) begin
               if (req.mode[0]) begin
                  nxt.idx = t;
               end else begin
                  nxt.acc = t;
               end
            end
         end
         MODE_MOVFLGA: nxt.acc = {{(WORD_W-FLAG_W){1'b0}}, cur.flags};
         MODE_MOVAFLG: f = cur.acc[FLAG_W-1:0];
         MODE_STOP:    rsp.halt = 1'b1;
         default:      rsp.illegal = 1'b1;
      endcase
      nxt.flags = f;
   end

endmodule

/* src/accumulator_cpu_execute_unit_top.sv */
// Execute unit for a 16-bit accumulator machine. A transaction is taken into an
// input register, executed in one pass of combinational logic against the A, X,
// SP and flag registers, and the result lands in the output register when the
// input register advances. One transaction per cycle is sustained while the
// result side is ready: the architectural registers are written at the same edge
// as the result register, so the next transaction sees them on its own pass. A
// stalled output holds the input register, which in turn stalls the request side.
// depends on acpu_pkg, acpu_exec and accumulator_cpu_execute_unit_top_macros.svh
`timescale 1ns / 1ps
`include "accumulator_cpu_execute_unit_top_macros.svh"

module accumulator_cpu_execute_unit_top import acpu_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [MODE_W-1:0] req_mode,
   input  logic [WORD_W-1:0] req_operand,
   input  logic [WORD_W-1:0] req_next_pc,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [WORD_W-1:0] rsp_new_pc,
   output logic              rsp_store_valid,
   output logic              rsp_store_byte,
   output logic [WORD_W-1:0] rsp_store_address,
   output logic [WORD_W-1:0] rsp_store_data,
   output logic [FLAG_W-1:0] rsp_flags_out,
   output logic [WORD_W-1:0] rsp_acc_value,
   output logic [WORD_W-1:0] rsp_index_value,
   output logic [WORD_W-1:0] rsp_stack_value,
   output logic              rsp_halt,
   output logic              rsp_illegal
);

   logic     in_valid_ff;
   logic     in_valid_in;
   req_type  in_ff;
   req_type  in_in;
   logic     out_valid_ff;
   logic     out_valid_in;
   rsp_type  out_ff;
   rsp_type  out_in;
   arch_type arch_ff;
   arch_type arch_in;
   arch_type exec_nxt;
   rsp_type  exec_rsp;
   logic     advance;
   logic     req_take;

   acpu_exec u_exec (
      .req (in_ff),
      .cur (arch_ff),
      .nxt (exec_nxt),
      .rsp (exec_rsp)
   );

   assign advance   = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;
   assign req_take  = req_valid & req_ready;

   always_comb begin
      in_valid_in  = req_take | (in_valid_ff & ~advance);
      in_in        = req_take ? req_type'({req_mode, req_operand, req_next_pc}) : in_ff;
      out_valid_in = advance | (out_valid_ff & ~rsp_ready);
      out_in       = advance ? exec_rsp : out_ff;
      arch_in      = advance ? exec_nxt : arch_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         arch_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         arch_ff      <= arch_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      out_ff <= out_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_new_pc        = out_ff.new_pc;
   assign rsp_store_valid   = out_ff.store_valid;
   assign rsp_store_byte    = out_ff.store_byte;
   assign rsp_store_address = out_ff.store_address;
   assign rsp_store_data    = out_ff.store_data;
   assign rsp_halt          = out_ff.halt;
   assign rsp_illegal       = out_ff.illegal;
   assign rsp_flags_out     = arch_ff.flags;
   assign rsp_acc_value     = arch_ff.acc;
   assign rsp_index_value   = arch_ff.idx;
   assign rsp_stack_value   = arch_ff.sp;

   // an executed transaction always shows up on the result side
   `ACPU_ASSERT_NEXT(a_advance_gives_rsp, advance, out_valid_ff)
   // illegal or stop leaves the architectural state untouched
   `ACPU_ASSERT_NEXT(a_no_side_effect, advance && (exec_rsp.illegal || exec_rsp.halt), $stable(arch_ff))
   // byte writes carry only the low byte
   `ACPU_ASSERT_IMPLY(a_byte_store, out_valid_ff && out_ff.store_byte, out_ff.store_valid && (out_ff.store_data[WORD_W-1:8] == 8'd0))
   // the input stage holds only while a result waits unconsumed on the result side
   `ACPU_ASSERT_IMPLY(a_stall_holds, in_valid_ff && !advance, out_valid_ff && !rsp_ready)

endmodule
